### rtl/ffsa_pkg.sv
package ffsa_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int ADDR_BITS = 16;
    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam int OP_W      = 2;
    localparam int SLOT_W    = 4;
    localparam int SIZE_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int ADDR_W    = 17;
    localparam int MOVED_W   = 5;
    localparam int BASE_W    = 16;
    localparam int ACTIVE_W  = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_COMPACT = 2'd2
    } op_t;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_ROOM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SLOT_CHK,
        ST_SCAN,
        ST_EVAL,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 held_set;
        logic                 held_clr;
        logic [SLOT_BITS-1:0] idx;
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
    } tbl_cmd_t;

    typedef struct packed {
        logic                 start;
        logic                 have_low;
        logic [ADDR_BITS-1:0] low;
    } scan_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic                 found;
        logic [SLOT_BITS-1:0] idx;
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
    } scan_res_t;

endpackage

### rtl/ffsa_table.sv
module ffsa_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffsa_pkg::tbl_cmd_t                 cmd,
    input  logic [ffsa_pkg::SLOT_BITS-1:0]     rd_addr,
    output logic [ffsa_pkg::ADDR_BITS-1:0]     rd_start,
    output logic [ffsa_pkg::SIZE_W-1:0]        rd_size,
    output logic [ffsa_pkg::NUM_SLOTS-1:0]     held
);
    import ffsa_pkg::*;

    logic [ADDR_BITS+SIZE_W-1:0] slot_mem [NUM_SLOTS];
    logic [ADDR_BITS+SIZE_W-1:0] rd_data_reg;
    logic [NUM_SLOTS-1:0]        held_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            slot_mem[cmd.idx] <= {cmd.start, cmd.size};
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (cmd.held_set)
        begin
            held_reg[cmd.idx] <= 1'b1;
        end
        else if (cmd.held_clr)
        begin
            held_reg[cmd.idx] <= 1'b0;
        end
    end

    assign rd_start = rd_data_reg[ADDR_BITS+SIZE_W-1:SIZE_W];
    assign rd_size  = rd_data_reg[SIZE_W-1:0];
    assign held     = held_reg;

endmodule

### rtl/ffsa_scan.sv
module ffsa_scan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffsa_pkg::scan_req_t                req,
    input  logic [ffsa_pkg::CNT_W-1:0]         live_cnt,
    input  logic [ffsa_pkg::NUM_SLOTS-1:0]     held,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]     rd_start,
    input  logic [ffsa_pkg::SIZE_W-1:0]        rd_size,
    output logic [ffsa_pkg::SLOT_BITS-1:0]     rd_addr,
    output ffsa_pkg::scan_res_t                res
);
    import ffsa_pkg::*;

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [SLOT_BITS-1:0] cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [ADDR_BITS-1:0] start_reg, start_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic                 issue_more;
    logic                 done;
    logic                 better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        idx_reg     <= idx_next;
        start_reg   <= start_next;
        size_reg    <= size_next;
    end

    always_comb
    begin
        issue_more     = busy_reg && (issue_reg < live_cnt);
        done           = busy_reg && !issue_more && !cmp_valid_reg;
        better         = cmp_valid_reg && held[cmp_idx_reg]
                         && (!req.have_low || (rd_start > req.low))
                         && (!found_reg || (rd_start < start_reg));
        busy_next      = busy_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = issue_reg[SLOT_BITS-1:0];
        found_next     = found_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        size_next      = size_reg;

        if (better)
        begin
            found_next = 1'b1;
            idx_next   = cmp_idx_reg;
            start_next = rd_start;
            size_next  = rd_size;
        end

        if (req.start && !busy_reg)
        begin
            busy_next  = 1'b1;
            issue_next = '0;
            found_next = 1'b0;
        end
        else if (busy_reg)
        begin
            cmp_valid_next = issue_more;
            if (issue_more)
            begin
                issue_next = issue_reg + CNT_W'(1);
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign rd_addr   = issue_reg[SLOT_BITS-1:0];
    assign res.busy  = busy_reg;
    assign res.done  = done;
    assign res.found = found_reg;
    assign res.idx   = idx_reg;
    assign res.start = start_reg;
    assign res.size  = size_reg;

endmodule

### rtl/ffsa_ctrl.sv
module ffsa_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ffsa_pkg::OP_W-1:0]          op,
    input  logic [ffsa_pkg::SLOT_W-1:0]        slot,
    input  logic [ffsa_pkg::SIZE_W-1:0]        req_size,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ffsa_pkg::STATUS_W-1:0]      status,
    output logic [ffsa_pkg::ADDR_W-1:0]        address,
    output logic [ffsa_pkg::MOVED_W-1:0]       moved,
    input  logic [ffsa_pkg::BASE_W-1:0]        pool_base,
    input  logic [ffsa_pkg::SIZE_W-1:0]        pool_size,
    input  logic [ffsa_pkg::CNT_W-1:0]         live_cnt,
    input  logic [ffsa_pkg::NUM_SLOTS-1:0]     held,
    input  logic [ffsa_pkg::ADDR_BITS-1:0]     rd_start,
    input  logic [ffsa_pkg::SIZE_W-1:0]        rd_size,
    input  ffsa_pkg::scan_res_t                scan_res,
    output logic [ffsa_pkg::SLOT_BITS-1:0]     slot_addr,
    output ffsa_pkg::tbl_cmd_t                 tbl_cmd,
    output ffsa_pkg::scan_req_t                scan_req
);
    import ffsa_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [SIZE_W-1:0]    req_reg, req_next;
    logic                 first_reg, first_next;
    logic                 have_low_reg, have_low_next;
    logic [ADDR_BITS-1:0] cur_start_reg, cur_start_next;
    logic [SIZE_W-1:0]    cur_size_reg, cur_size_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0] res_off_reg, res_off_next;
    logic                 res_grant_reg, res_grant_next;
    logic [MOVED_W-1:0]   moved_reg, moved_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [ADDR_W-1:0]    out_address_reg, out_address_next;
    logic [MOVED_W-1:0]   out_moved_reg, out_moved_next;
    logic                 out_of_range;
    logic [ADDR_BITS:0]   end_sum;
    logic [ADDR_BITS+1:0] need;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        slot_reg        <= slot_next;
        req_reg         <= req_next;
        first_reg       <= first_next;
        have_low_reg    <= have_low_next;
        cur_start_reg   <= cur_start_next;
        cur_size_reg    <= cur_size_next;
        res_status_reg  <= res_status_next;
        res_off_reg     <= res_off_next;
        res_grant_reg   <= res_grant_next;
        moved_reg       <= moved_next;
        out_status_reg  <= out_status_next;
        out_address_reg <= out_address_next;
        out_moved_reg   <= out_moved_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        slot_next        = slot_reg;
        req_next         = req_reg;
        first_next       = first_reg;
        have_low_next    = have_low_reg;
        cur_start_next   = cur_start_reg;
        cur_size_next    = cur_size_reg;
        res_status_next  = res_status_reg;
        res_off_next     = res_off_reg;
        res_grant_next   = res_grant_reg;
        moved_next       = moved_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_address_next = out_address_reg;
        out_moved_next   = out_moved_reg;

        tbl_cmd          = '0;
        tbl_cmd.idx      = slot_reg[SLOT_BITS-1:0];
        scan_req.start    = 1'b0;
        scan_req.have_low = have_low_reg;
        scan_req.low      = cur_start_reg;

        in_ready     = (state_reg == ST_IDLE);
        out_of_range = (CNT_W'(slot_reg) >= live_cnt);
        end_sum      = {1'b0, cur_start_reg} + {1'b0, cur_size_reg};
        need         = {1'b0, end_sum} + {2'b00, req_reg};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = op;
                    slot_next       = slot;
                    req_next        = req_size;
                    res_status_next = STATUS_OK;
                    res_off_next    = '0;
                    res_grant_next  = 1'b0;
                    moved_next      = '0;
                    state_next      = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (out_of_range)
                        begin
                            res_status_next = STATUS_RANGE;
                            state_next      = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_SLOT_CHK;
                        end
                    end
                    OP_FREE:
                    begin
                        if (out_of_range)
                        begin
                            res_status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            tbl_cmd.held_clr = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end
                    OP_COMPACT:
                    begin
                        scan_req.start = 1'b1;
                        have_low_next  = 1'b0;
                        first_next     = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_SLOT_CHK:
            begin
                if (held[slot_reg[SLOT_BITS-1:0]] && (rd_size >= req_reg))
                begin
                    tbl_cmd.wr_en  = 1'b1;
                    tbl_cmd.start  = rd_start;
                    tbl_cmd.size   = req_reg;
                    res_off_next   = rd_start;
                    res_grant_next = 1'b1;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    tbl_cmd.held_clr = 1'b1;
                    scan_req.start   = 1'b1;
                    have_low_next    = 1'b0;
                    first_next       = 1'b1;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (first_reg && !scan_res.found)
                    begin
                        if (req_reg <= pool_size)
                        begin
                            tbl_cmd.wr_en    = 1'b1;
                            tbl_cmd.held_set = 1'b1;
                            tbl_cmd.start    = '0;
                            tbl_cmd.size     = req_reg;
                            res_off_next     = '0;
                            res_grant_next   = 1'b1;
                        end
                        else
                        begin
                            res_status_next = STATUS_NO_ROOM;
                        end
                        state_next = ST_FINISH;
                    end
                    else if (first_reg && (scan_res.start != '0)
                             && (scan_res.start >= req_reg))
                    begin
                        tbl_cmd.wr_en    = 1'b1;
                        tbl_cmd.held_set = 1'b1;
                        tbl_cmd.start    = '0;
                        tbl_cmd.size     = req_reg;
                        res_off_next     = '0;
                        res_grant_next   = 1'b1;
                        state_next       = ST_FINISH;
                    end
                    else if (first_reg)
                    begin
                        cur_start_next = scan_res.start;
                        cur_size_next  = scan_res.size;
                        scan_req.start = 1'b1;
                        have_low_next  = 1'b1;
                        first_next     = 1'b0;
                        state_next     = ST_SCAN;
                    end
                    else if (scan_res.found && ({2'b00, scan_res.start} < need))
                    begin
                        cur_start_next = scan_res.start;
                        cur_size_next  = scan_res.size;
                        scan_req.start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else if (scan_res.found || (need <= {2'b00, pool_size}))
                    begin
                        tbl_cmd.wr_en    = 1'b1;
                        tbl_cmd.held_set = 1'b1;
                        tbl_cmd.start    = end_sum[ADDR_BITS-1:0];
                        tbl_cmd.size     = req_reg;
                        res_off_next     = end_sum[ADDR_BITS-1:0];
                        res_grant_next   = 1'b1;
                        state_next       = ST_FINISH;
                    end
                    else
                    begin
                        res_status_next = STATUS_NO_ROOM;
                        state_next      = ST_FINISH;
                    end
                end
                else
                begin
                    if (!scan_res.found)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        tbl_cmd.idx    = scan_res.idx;
                        tbl_cmd.size   = scan_res.size;
                        cur_size_next  = scan_res.size;
                        cur_start_next = scan_res.start;
                        if (first_reg && (scan_res.start != '0))
                        begin
                            tbl_cmd.wr_en  = 1'b1;
                            tbl_cmd.start  = '0;
                            cur_start_next = '0;
                            moved_next     = MOVED_W'(1);
                        end
                        else if (!first_reg && ({1'b0, scan_res.start} > end_sum))
                        begin
                            tbl_cmd.wr_en  = 1'b1;
                            tbl_cmd.start  = end_sum[ADDR_BITS-1:0];
                            cur_start_next = end_sum[ADDR_BITS-1:0];
                            moved_next     = moved_reg + MOVED_W'(1);
                        end
                        scan_req.start = 1'b1;
                        have_low_next  = 1'b1;
                        first_next     = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_moved_next  = moved_reg;
                    if (res_grant_reg)
                    begin
                        out_address_next = {1'b0, pool_base} + {1'b0, res_off_reg};
                    end
                    else
                    begin
                        out_address_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign slot_addr = slot_reg[SLOT_BITS-1:0];
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign address   = out_address_reg;
    assign moved     = out_moved_reg;

endmodule

### rtl/first_fit_slot_allocator_top.sv
// A free, an out-of-range request or an unused op goes from dispatch straight to the finish state.
// An allocate makes up to live_count scan passes and a compact up to live_count + 1.
// Throughput: one item at a time; the next input transfer is taken once the result is
// registered, while that result may still wait for its output transfer.
// Reset clears all held flags and loads pool_base 0, pool_size 65535 and active_slots 16.
module first_fit_slot_allocator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ffsa_pkg::OP_W-1:0]          op,
    input  logic [ffsa_pkg::SLOT_W-1:0]        slot,
    input  logic [ffsa_pkg::SIZE_W-1:0]        req_size,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ffsa_pkg::STATUS_W-1:0]      status,
    output logic [ffsa_pkg::ADDR_W-1:0]        address,
    output logic [ffsa_pkg::MOVED_W-1:0]       moved,
    input  logic                               cfg_we,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffsa_pkg::CFG_W-1:0]         cfg_data
);
    import ffsa_pkg::*;

    logic [BASE_W-1:0]    pool_base_reg;
    logic [SIZE_W-1:0]    pool_size_reg;
    logic [ACTIVE_W-1:0]  active_slots_reg;
    logic [CNT_W-1:0]     live_cnt;
    tbl_cmd_t             tbl_cmd;
    scan_req_t            scan_req;
    scan_res_t            scan_res;
    logic [NUM_SLOTS-1:0] held;
    logic [ADDR_BITS-1:0] rd_start;
    logic [SIZE_W-1:0]    rd_size;
    logic [SLOT_BITS-1:0] scan_addr;
    logic [SLOT_BITS-1:0] slot_addr;
    logic [SLOT_BITS-1:0] rd_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg    <= '0;
            pool_size_reg    <= '1;
            active_slots_reg <= ACTIVE_W'(NUM_SLOTS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POOL_BASE:    pool_base_reg    <= cfg_data[BASE_W-1:0];
                REG_POOL_SIZE:    pool_size_reg    <= cfg_data[SIZE_W-1:0];
                REG_ACTIVE_SLOTS: active_slots_reg <= cfg_data[ACTIVE_W-1:0];
                default:          ;
            endcase
        end
    end

    assign live_cnt = (active_slots_reg < ACTIVE_W'(NUM_SLOTS))
                      ? CNT_W'(active_slots_reg) : CNT_W'(NUM_SLOTS);
    assign rd_addr  = scan_res.busy ? scan_addr : slot_addr;

    ffsa_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (tbl_cmd),
        .rd_addr  (rd_addr),
        .rd_start (rd_start),
        .rd_size  (rd_size),
        .held     (held)
    );

    ffsa_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (scan_req),
        .live_cnt (live_cnt),
        .held     (held),
        .rd_start (rd_start),
        .rd_size  (rd_size),
        .rd_addr  (scan_addr),
        .res      (scan_res)
    );

    ffsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .slot      (slot),
        .req_size  (req_size),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .address   (address),
        .moved     (moved),
        .pool_base (pool_base_reg),
        .pool_size (pool_size_reg),
        .live_cnt  (live_cnt),
        .held      (held),
        .rd_start  (rd_start),
        .rd_size   (rd_size),
        .scan_res  (scan_res),
        .slot_addr (slot_addr),
        .tbl_cmd   (tbl_cmd),
        .scan_req  (scan_req)
    );

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted again right after a transfer");

    a_no_scan_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !scan_res.busy)
        else $error("scan unit busy while the block is ready");

    a_range_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_RANGE) |-> (address == '0) && (moved == '0))
        else $error("out-of-range result carries an address or move count");

    a_moved_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (MOVED_W'(moved) <= MOVED_W'(NUM_SLOTS)))
        else $error("move count exceeds the slot count");

endmodule
